@@ design/lli_pkg.sv @@
// Package for the line-line intersection block: widths, status codes and the
// record passed along the divider cell row. No dependencies.
package lli_pkg;

  localparam int COORD_BITS          = 16;
  localparam int EXTRA_FRACTION_BITS = 8;
  localparam int OUT_BITS            = 40;

  localparam int AB_W  = COORD_BITS + 1;
  localparam int P_W   = 2 * COORD_BITS;
  localparam int C_W   = 2 * COORD_BITS + 1;
  localparam int Q_W   = 2 * AB_W;
  localparam int DEN_W = 2 * AB_W + 1;
  localparam int M_W   = C_W + AB_W;
  localparam int NUM_W = M_W + 1;
  localparam int NQ_W  = NUM_W + EXTRA_FRACTION_BITS;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_DEGEN    = 2'd2
  } status_e;

  typedef struct packed {
    status_e                 st;
    logic                    neg_x;
    logic                    neg_y;
    logic [DEN_W-1:0]        den;
    logic [DEN_W-1:0]        rem_x;
    logic [DEN_W-1:0]        rem_y;
    logic [NQ_W-1:0]         nq_x;
    logic [NQ_W-1:0]         nq_y;
  } lli_div_t;

endpackage

@@ design/line_line_intersection.sv @@
// Line-line intersection by Cramer's rule: one line pair per cycle, fully
// pipelined: three multiply stages, then one divider cell per quotient bit,
// then the output register. A new pair is taken every cycle while the output
// is free or drained.
// Depends on lli_pkg, lli_front and lli_cell.
module line_line_intersection
  import lli_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sx1, sy1, ex1, ey1, sx2, sy2, ex2, ey2, 16 bits each from bit 0
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cross_x [39:0], cross_y [79:40], saturated [80], zeros [87:81]
  output logic [87:0]  m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]   m_axis_tuser_o
);

  localparam logic [NQ_W-1:0] LimPos = NQ_W'((64'd1 << (OUT_BITS - 1)) - 64'd1);
  localparam logic [NQ_W-1:0] LimNeg = NQ_W'(64'd1 << (OUT_BITS - 1));

  logic en;
  logic     vld [0:NQ_W];
  lli_div_t dat [0:NQ_W];

  logic                out_vld_q;
  status_e             st_q;
  logic [OUT_BITS-1:0] x_q, y_q, x_d, y_d;
  logic                sat_q, sat_d;
  logic [NQ_W-1:0]     lim_x, lim_y, qx, qy;
  logic                sx, sy;
  logic [OUT_BITS-1:0] mx, my;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  lli_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .sx1_i   (s_axis_tdata_i[15:0]),
    .sy1_i   (s_axis_tdata_i[31:16]),
    .ex1_i   (s_axis_tdata_i[47:32]),
    .ey1_i   (s_axis_tdata_i[63:48]),
    .sx2_i   (s_axis_tdata_i[79:64]),
    .sy2_i   (s_axis_tdata_i[95:80]),
    .ex2_i   (s_axis_tdata_i[111:96]),
    .ey2_i   (s_axis_tdata_i[127:112]),
    .valid_o (vld[0]),
    .data_o  (dat[0])
  );

  for (genvar i = 0; i < NQ_W; i++) begin : g_cell
    lli_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .data_i  (dat[i]),
      .valid_o (vld[i+1]),
      .data_o  (dat[i+1])
    );
  end

  // clamp magnitudes, then apply sign; non-hit results read as zero
  assign qx    = dat[NQ_W].nq_x;
  assign qy    = dat[NQ_W].nq_y;
  assign lim_x = dat[NQ_W].neg_x ? LimNeg : LimPos;
  assign lim_y = dat[NQ_W].neg_y ? LimNeg : LimPos;
  assign sx    = qx > lim_x;
  assign sy    = qy > lim_y;
  assign mx    = sx ? OUT_BITS'(lim_x) : OUT_BITS'(qx);
  assign my    = sy ? OUT_BITS'(lim_y) : OUT_BITS'(qy);

  always_comb begin
    if (dat[NQ_W].st == ST_HIT) begin
      x_d   = dat[NQ_W].neg_x ? OUT_BITS'(-mx) : mx;
      y_d   = dat[NQ_W].neg_y ? OUT_BITS'(-my) : my;
      sat_d = sx || sy;
    end else begin
      x_d   = '0;
      y_d   = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NQ_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= dat[NQ_W].st;
      x_q   <= x_d;
      y_q   <= y_d;
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, sat_q, y_q, x_q};
  assign m_axis_tuser_o  = st_q;

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_HIT)) |->
      ((x_q == '0) && (y_q == '0) && !sat_q))
    else $error("non-hit result carries data");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && sat_q) |->
      ((x_q == OUT_BITS'(LimPos)) || (x_q == OUT_BITS'(LimNeg)) ||
       (y_q == OUT_BITS'(LimPos)) || (y_q == OUT_BITS'(LimNeg))))
    else $error("saturated flag without clamped coordinate");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld[0]) && $stable(vld[NQ_W]))
    else $error("pipeline moved during stall");
`endif

endmodule

@@ design/lli_front.sv @@
// Front end: line coefficients, determinant and Cramer numerators over three
// register stages. Depends on lli_pkg.
module lli_front
  import lli_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] sx1_i,
  input  logic signed [COORD_BITS-1:0] sy1_i,
  input  logic signed [COORD_BITS-1:0] ex1_i,
  input  logic signed [COORD_BITS-1:0] ey1_i,
  input  logic signed [COORD_BITS-1:0] sx2_i,
  input  logic signed [COORD_BITS-1:0] sy2_i,
  input  logic signed [COORD_BITS-1:0] ex2_i,
  input  logic signed [COORD_BITS-1:0] ey2_i,
  output logic                         valid_o,
  output lli_div_t                     data_o
);

  logic [2:0] vld_q;

  logic signed [AB_W-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [P_W-1:0]  p1a_q, p1b_q, p2a_q, p2b_q;

  logic signed [AB_W-1:0] a1_r_q, b1_r_q, a2_r_q, b2_r_q;
  logic signed [C_W-1:0]  c1_q, c2_q;
  logic signed [Q_W-1:0]  q1_q, q2_q;

  logic signed [DEN_W-1:0] den_q;
  logic signed [M_W-1:0]   m1_q, m2_q, m3_q, m4_q;
  logic                    degen_q;

  logic signed [C_W-1:0]   c1_d, c2_d;
  logic signed [DEN_W-1:0] den_d;
  logic signed [NUM_W-1:0] nx, ny;
  logic [NUM_W-1:0]        mag_x, mag_y;
  logic                    nneg_x, nneg_y, dneg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign c1_d  = C_W'(p1a_q) - C_W'(p1b_q);
  assign c2_d  = C_W'(p2a_q) - C_W'(p2b_q);
  assign den_d = DEN_W'(q1_q) - DEN_W'(q2_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= AB_W'(sy1_i) - AB_W'(ey1_i);
      b1_q  <= AB_W'(ex1_i) - AB_W'(sx1_i);
      a2_q  <= AB_W'(sy2_i) - AB_W'(ey2_i);
      b2_q  <= AB_W'(ex2_i) - AB_W'(sx2_i);
      p1a_q <= P_W'(ex1_i) * P_W'(sy1_i);
      p1b_q <= P_W'(ey1_i) * P_W'(sx1_i);
      p2a_q <= P_W'(ex2_i) * P_W'(sy2_i);
      p2b_q <= P_W'(ey2_i) * P_W'(sx2_i);

      a1_r_q <= a1_q;
      b1_r_q <= b1_q;
      a2_r_q <= a2_q;
      b2_r_q <= b2_q;
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      q1_q   <= Q_W'(a1_q) * Q_W'(b2_q);
      q2_q   <= Q_W'(b1_q) * Q_W'(a2_q);

      den_q   <= den_d;
      m1_q    <= M_W'(c1_q) * M_W'(b2_r_q);
      m2_q    <= M_W'(b1_r_q) * M_W'(c2_q);
      m3_q    <= M_W'(a1_r_q) * M_W'(c2_q);
      m4_q    <= M_W'(c1_q) * M_W'(a2_r_q);
      degen_q <= ((a1_r_q == '0) && (b1_r_q == '0)) || ((a2_r_q == '0) && (b2_r_q == '0));
    end
  end

  assign nx     = NUM_W'(m1_q) - NUM_W'(m2_q);
  assign ny     = NUM_W'(m3_q) - NUM_W'(m4_q);
  assign nneg_x = nx[NUM_W-1];
  assign nneg_y = ny[NUM_W-1];
  assign dneg   = den_q[DEN_W-1];
  assign mag_x  = nneg_x ? NUM_W'(-nx) : NUM_W'(nx);
  assign mag_y  = nneg_y ? NUM_W'(-ny) : NUM_W'(ny);

  always_comb begin
    data_o.st    = degen_q ? ST_DEGEN : ((den_q == '0) ? ST_PARALLEL : ST_HIT);
    data_o.neg_x = nneg_x ^ dneg;
    data_o.neg_y = nneg_y ^ dneg;
    data_o.den   = dneg ? DEN_W'(-den_q) : DEN_W'(den_q);
    data_o.rem_x = '0;
    data_o.rem_y = '0;
    data_o.nq_x  = NQ_W'(mag_x) << EXTRA_FRACTION_BITS;
    data_o.nq_y  = NQ_W'(mag_y) << EXTRA_FRACTION_BITS;
  end

  assign valid_o = vld_q[2];

endmodule

@@ design/lli_cell.sv @@
// One restoring-division cell: develops one quotient bit of both the x and
// the y quotient and hands the record on. Depends on lli_pkg.
module lli_cell
  import lli_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  lli_div_t data_i,
  output logic     valid_o,
  output lli_div_t data_o
);

  logic     valid_q;
  lli_div_t data_q, data_d;
  logic [DEN_W:0] tx, ty, dd;
  logic           gx, gy;

  assign dd = {1'b0, data_i.den};
  assign tx = {data_i.rem_x, data_i.nq_x[NQ_W-1]};
  assign ty = {data_i.rem_y, data_i.nq_y[NQ_W-1]};
  assign gx = (tx >= dd);
  assign gy = (ty >= dd);

  always_comb begin
    data_d       = data_i;
    data_d.rem_x = gx ? DEN_W'(tx - dd) : DEN_W'(tx);
    data_d.rem_y = gy ? DEN_W'(ty - dd) : DEN_W'(ty);
    // shift the next numerator bit out, the quotient bit in
    data_d.nq_x  = {data_i.nq_x[NQ_W-2:0], gx};
    data_d.nq_y  = {data_i.nq_y[NQ_W-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
